>>> sv/websocket_frame_deframer_unit_assert.svh
// Assertion macros used by the deframer's top-level RTL file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define WFD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
// Next-cycle implication, disabled while reset is high.
`define WFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define WFD_ASSERT_IMP(label, clk, rst, ante, cons)
`define WFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/wfd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wfd_pkg;

  // Default width of the payload length counter.
  localparam int LENGTH_BITS_DEF = 64;

  // Parser phases.
  localparam logic [1:0] PH_HDR0 = 2'd0;
  localparam logic [1:0] PH_HDR1 = 2'd1;
  localparam logic [1:0] PH_EXT  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  // Header field masks and length escape codes.
  localparam logic [7:0] FIN_MASK    = 8'h80;
  localparam logic [7:0] OPCODE_MASK = 8'h0F;
  localparam logic [7:0] LEN7_MASK   = 8'h7F;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;

  // Number of extended length bytes for each escape.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Result queue between parser and output.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One result item.
  typedef struct packed {
    logic       frame_final;
    logic [3:0] frame_opcode;
    logic [7:0] payload_byte;
    logic       has_data;
    logic       frame_end;
  } wfd_item_t;

endpackage

>>> sv/wfd_parser.sv
// Front end: header parser that turns received bytes into result items.
module wfd_parser
  import wfd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       queue_full,
  output logic       push,
  output wfd_item_t  item
);

  logic [1:0]             phase, phase_next;
  logic                   final_flag, final_flag_next;
  logic [3:0]             opcode_reg, opcode_reg_next;
  logic [3:0]             ext_left, ext_left_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic                   take;
  logic [6:0]             len7;
  logic [LENGTH_BITS-1:0] shifted;

  // A byte is taken whenever the queue can hold a possible result.
  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;
  assign len7     = 7'(in_byte & LEN7_MASK);
  assign shifted  = {remaining[LENGTH_BITS-9:0], in_byte};

  // Next-state and result decode for the accepted byte.
  always_comb begin
    phase_next      = phase;
    final_flag_next = final_flag;
    opcode_reg_next = opcode_reg;
    ext_left_next   = ext_left;
    remaining_next  = remaining;
    push            = 1'b0;
    item.frame_final  = final_flag;
    item.frame_opcode = opcode_reg;
    item.payload_byte = 8'd0;
    item.has_data     = 1'b0;
    item.frame_end    = 1'b1;
    unique case (phase)
      PH_HDR0: begin
        final_flag_next = (in_byte & FIN_MASK) != 8'd0;
        opcode_reg_next = 4'(in_byte & OPCODE_MASK);
        phase_next      = PH_HDR1;
      end
      PH_HDR1: begin
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          ext_left_next  = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          remaining_next = '0;
          phase_next     = PH_EXT;
        end else begin
          remaining_next = LENGTH_BITS'(len7);
          if (len7 == 7'd0) begin
            // Empty frame: one marker result, then the next header.
            phase_next = PH_HDR0;
            push       = take;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_EXT: begin
        remaining_next = shifted;
        ext_left_next  = ext_left - 4'd1;
        if (ext_left == 4'd1) begin
          if (shifted == '0) begin
            phase_next = PH_HDR0;
            push       = take;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        remaining_next    = remaining - LENGTH_BITS'(1);
        item.payload_byte = in_byte;
        item.has_data     = 1'b1;
        item.frame_end    = (remaining == LENGTH_BITS'(1));
        push              = take;
        if (remaining == LENGTH_BITS'(1)) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      final_flag <= 1'b0;
      opcode_reg <= 4'd0;
      ext_left   <= 4'd0;
      remaining  <= '0;
    end else if (take) begin
      phase      <= phase_next;
      final_flag <= final_flag_next;
      opcode_reg <= opcode_reg_next;
      ext_left   <= ext_left_next;
      remaining  <= remaining_next;
    end
  end

endmodule

>>> sv/wfd_queue.sv
// Back end: short result queue that drives the output stream.
module wfd_queue
  import wfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  wfd_item_t push_item,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output wfd_item_t out_item
);

  wfd_item_t          entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = entries[rd_ptr];

  // Storage write side.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/websocket_frame_deframer_unit.sv
// WebSocket frame deframer: takes one received byte per cycle while the
// result queue is not full; header and extended length bytes give no output,
// payload bytes and empty-frame markers each give one transfer on the output
// stream once their registered result reaches the queue head. A two-entry
// result queue separates the header parser from the output, so the input
// keeps running while one result waits and stalls only once two are queued.
// Mask and reserved bits are passed over; masked payload is passed as received.
`include "websocket_frame_deframer_unit_assert.svh"

module websocket_frame_deframer_unit
  import wfd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tlast,   // frame_end
  output logic [5:0] m_axis_tuser    // [0] frame_final, [4:1] frame_opcode, [5] has_data
);

  logic      push;
  logic      q_full;
  wfd_item_t parse_item;
  wfd_item_t head_item;

  // Front end: header parsing.
  wfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .queue_full(q_full),
    .push      (push),
    .item      (parse_item)
  );

  // Back end: result queue and output stream.
  wfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(parse_item),
    .full     (q_full),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_item (head_item)
  );

  // Output field packing.
  assign m_axis_tdata = head_item.payload_byte;
  assign m_axis_tlast = head_item.frame_end;
  assign m_axis_tuser = {head_item.has_data, head_item.frame_opcode, head_item.frame_final};

  // The parser never writes into a full queue.
  `WFD_ASSERT_IMP(a_no_overflow, clk, rst, push, !q_full)
  // An empty-frame marker carries a zero byte and closes its frame.
  `WFD_ASSERT_IMP(a_marker_form, clk, rst, m_axis_tvalid && !m_axis_tuser[5],
                  m_axis_tlast && (m_axis_tdata == 8'd0))
  // A result pushed into an empty queue shows up on the output next cycle.
  `WFD_ASSERT_NEXT(a_push_visible, clk, rst, push && !m_axis_tvalid, m_axis_tvalid)

endmodule
